// ===== hdl/dsc_pkg.sv =====
// shared types, constants and helper functions of the defended set closure block
// used by every module under hdl; depends on nothing else
`timescale 1ns / 1ps

package dsc_pkg;

  // argument count of the stored graph and the fixed lane width of the mask fields
  localparam int ARGS  = 32;
  localparam int LANES = 32;
  localparam int ROWS  = (ARGS < LANES) ? ARGS : LANES;

  localparam int IDX_W   = 5;
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 6;
  localparam int COUNT_W = 6;
  localparam int CNT_W   = $clog2(ROWS);

  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEED    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd3;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 6'd32;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  arg_index;
    logic [LANES-1:0]  row_bits;
  } dsc_in_t;

  typedef struct packed {
    logic [LANES-1:0]   closure_mask;
    logic [COUNT_W-1:0] member_count;
  } dsc_out_t;

  // per-round control seen by the whole chain
  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] idx;
    logic             pass_bad;
    logic [LANES-1:0] cur;
    logic [LANES-1:0] hit;
    logic [LANES-1:0] act;
  } dsc_chain_ctl_t;

  // the slice of that control one cell needs
  typedef struct packed {
    logic wr_en;
    logic pass_bad;
    logic cur_bit;
    logic hit_bit;
    logic act_bit;
  } dsc_cell_ctl_t;

  function automatic logic [LANES-1:0] active_mask(logic [CFG_W-1:0] n);
    logic [LANES-1:0] m;
    for (int j = 0; j < LANES; j++) begin
      m[j] = (j < int'(n)) && (j < ROWS);
    end
    return m;
  endfunction

  // count per byte, then add the four byte counts
  function automatic logic [COUNT_W-1:0] pop_count(logic [LANES-1:0] v);
    logic [3:0]         byte_cnt;
    logic [COUNT_W-1:0] total;
    total = '0;
    for (int b = 0; b < LANES / 8; b++) begin
      byte_cnt = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt = byte_cnt + 4'(v[b*8+k]);
      end
      total = total + COUNT_W'(byte_cnt);
    end
    return total;
  endfunction

endpackage

// ===== hdl/dsc_cell.sv =====
// one chain cell: holds the attack row of one argument and ors it into the
// accumulator passed down the chain; uses dsc_pkg
`timescale 1ns / 1ps

module dsc_cell import dsc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  dsc_cell_ctl_t    ctl,
  input  logic [LANES-1:0] wr_row,
  input  logic [LANES-1:0] acc_in,
  output logic [LANES-1:0] acc_out
);

  logic [LANES-1:0] row_r, row_nxt;
  logic [LANES-1:0] acc_r, acc_nxt;
  logic             sel;

  always_comb begin
    row_nxt = ctl.wr_en ? wr_row : row_r;
    // hit pass: rows of members; bad pass: rows of active, undefended attackers
    sel     = ctl.pass_bad ? (ctl.act_bit & ~ctl.hit_bit) : (ctl.cur_bit & ctl.act_bit);
    acc_nxt = acc_in | (sel ? row_r : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc_out = acc_r;

endmodule

// ===== hdl/dsc_chain.sv =====
// row of dsc_cell instances, one per argument, with the accumulator rippling
// one cell per cycle; uses dsc_pkg and dsc_cell
`timescale 1ns / 1ps

module dsc_chain import dsc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  dsc_chain_ctl_t   ctl,
  input  logic [LANES-1:0] wr_row,
  output logic [LANES-1:0] acc_out
);

  logic [LANES-1:0] acc [ROWS+1];

  assign acc[0] = '0;

  for (genvar i = 0; i < ROWS; i++) begin : g_cell
    dsc_cell_ctl_t cctl;

    always_comb begin
      cctl.wr_en    = ctl.load && (ctl.idx == IDX_W'(i));
      cctl.pass_bad = ctl.pass_bad;
      cctl.cur_bit  = ctl.cur[i];
      cctl.hit_bit  = ctl.hit[i];
      cctl.act_bit  = ctl.act[i];
    end

    dsc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cctl),
      .wr_row  (wr_row),
      .acc_in  (acc[i]),
      .acc_out (acc[i+1])
    );
  end

  // the last cell holds the full or once steady inputs rippled through all cells
  assign acc_out = acc[ROWS];

endmodule

// ===== hdl/defended_set_closure.sv =====
// top level of the defended set closure block: item decode, seed and closure
// registers, round sequencer and result register; uses dsc_pkg and dsc_chain
//
// usage
//   in channel (in_valid / in_stall / in_data) carries one item per accept:
//   load an attack row, add a seed, clear the seeds, or compute the closure.
//   out channel (out_valid / out_stall / out_data) returns one item per
//   compute: the closure mask and its member count. cfg channel
//   (cfg_valid / cfg_ready / cfg_data) writes the active argument count;
//   it is always ready and is meant to be written while the block is idle.
// item handling
//   load, seed and clear items are accepted back to back.
//   a compute runs rounds over the cell chain; each round is a hit pass and
//   its capture state, then a defense pass and its capture state. rounds
//   run until the set stops growing, 1 to ROWS+1 of them.
// reset and stalls
//   synchronous reset clears all rows, the seeds and the closure and sets the
//   active count to 32. a stalled result holds on out_data; the block keeps
//   taking loads meanwhile, and a finished compute waits until the result
//   register is free.
`timescale 1ns / 1ps

module defended_set_closure import dsc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  dsc_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output dsc_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_HIT  = 6'b000010,
    ST_HCAP = 6'b000100,
    ST_BAD  = 6'b001000,
    ST_BCAP = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROWS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CFG_W-1:0] act_cnt_r, act_cnt_nxt;
  logic [LANES-1:0] seed_r, seed_nxt;
  logic [LANES-1:0] cur_r, cur_nxt;
  logic [LANES-1:0] hit_r, hit_nxt;
  logic             out_valid_r, out_valid_nxt;
  dsc_out_t         out_data_r, out_data_nxt;

  logic             in_acc;
  logic [LANES-1:0] act;
  logic [LANES-1:0] chain_acc;
  logic [LANES-1:0] next_set;
  dsc_chain_ctl_t   chain_ctl;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign act       = active_mask(act_cnt_r);
  // add every active argument that no undefended active attacker reaches
  assign next_set  = cur_r | (act & ~chain_acc);

  always_comb begin
    chain_ctl.load     = in_acc && (in_data.mode == MODE_LOAD);
    chain_ctl.idx      = in_data.arg_index;
    chain_ctl.pass_bad = (state_r == ST_BAD);
    chain_ctl.cur      = cur_r;
    chain_ctl.hit      = hit_r;
    chain_ctl.act      = act;
  end

  dsc_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (chain_ctl),
    .wr_row  (in_data.row_bits),
    .acc_out (chain_acc)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    act_cnt_nxt   = act_cnt_r;
    seed_nxt      = seed_r;
    cur_nxt       = cur_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (cfg_valid && cfg_ready) begin
      act_cnt_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data.mode)
            MODE_SEED: begin
              if (int'(in_data.arg_index) < ROWS) begin
                seed_nxt = seed_r | (LANES'(1) << in_data.arg_index);
              end
            end
            MODE_CLEAR: begin
              seed_nxt = '0;
            end
            MODE_COMPUTE: begin
              cur_nxt   = seed_r & act;
              cnt_nxt   = '0;
              state_nxt = ST_HIT;
            end
            default: begin
              // row loads are written in the chain
            end
          endcase
        end
      end
      ST_HIT: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_HCAP;
        end
      end
      ST_HCAP: begin
        hit_nxt   = chain_acc;
        cnt_nxt   = '0;
        state_nxt = ST_BAD;
      end
      ST_BAD: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_BCAP;
        end
      end
      ST_BCAP: begin
        if (next_set == cur_r) begin
          state_nxt = ST_FIN;
        end else begin
          cur_nxt   = next_set;
          cnt_nxt   = '0;
          state_nxt = ST_HIT;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.closure_mask = cur_r;
          out_data_nxt.member_count = pop_count(cur_r);
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      act_cnt_r   <= ACTIVE_RESET;
      seed_r      <= '0;
      cur_r       <= '0;
      hit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      act_cnt_r   <= act_cnt_nxt;
      seed_r      <= seed_nxt;
      cur_r       <= cur_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/dsc_checker.sv =====
// port-level checks of defended_set_closure over time, bound to the top level
// uses dsc_pkg
`timescale 1ns / 1ps

module dsc_checker import dsc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input dsc_in_t          in_data,
  input logic             out_valid,
  input logic             out_stall,
  input dsc_out_t         out_data
);

  // a result item is not dropped while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped under stall");

  // the member count matches the mask it goes with
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.member_count == COUNT_W'($countones(out_data.closure_mask))))
    else $error("member count does not match closure mask");

  // a compute item keeps the input side busy in the following cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.mode == MODE_COMPUTE) |=> in_stall)
    else $error("input taken right after a compute item");

  // no result item right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item shown after reset");

endmodule

bind defended_set_closure dsc_checker u_dsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== sim/defended_set_closure_tb.sv =====
// testbench for defended_set_closure, uses dsc_pkg: directed table, then random graph
// scenarios, closures checked against table results or an in-bench fixpoint predictor
`timescale 1ns / 1ps

module defended_set_closure_tb;
  import dsc_pkg::*;

  localparam int QUIET_LIMIT   = 25000;
  localparam int SETTLE_CYCLES = 2200;

  typedef struct {
    dsc_in_t  item;
    bit       has_ref;
    dsc_out_t ref_res;
  } directed_row_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  dsc_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  dsc_out_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  // predictor state
  logic [LANES-1:0] graph_rows [ROWS];
  logic [LANES-1:0] seed_set;
  logic [CFG_W-1:0] active_cnt;

  dsc_out_t      pending_closures [$];
  directed_row_t plan [$];
  int            mismatch_count = 0;
  int            quiet_cycles   = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  int            index_span     = ROWS;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  defended_set_closure i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // least set holding the seeds and every active argument it defends
  function automatic logic [LANES-1:0] defended_closure();
    logic [LANES-1:0] act;
    logic [LANES-1:0] cur;
    logic [LANES-1:0] hit;
    logic [LANES-1:0] nxt;
    int               lim;
    bit               grown;
    bit               ok;
    lim = (int'(active_cnt) > ROWS) ? ROWS : int'(active_cnt);
    act = '0;
    for (int j = 0; j < lim; j++) act[j] = 1'b1;
    cur = seed_set & act;
    grown = 1'b1;
    for (int r = 0; r <= ROWS && grown; r++) begin
      hit = '0;
      for (int i = 0; i < ROWS; i++) begin
        if (cur[i]) hit = hit | (graph_rows[i] & act);
      end
      nxt = cur;
      for (int x = 0; x < ROWS; x++) begin
        if (act[x]) begin
          ok = 1'b1;
          for (int i = 0; i < ROWS; i++) begin
            if (act[i] && graph_rows[i][x] && !hit[i]) ok = 1'b0;
          end
          if (ok) nxt[x] = 1'b1;
        end
      end
      grown = (nxt != cur);
      cur = nxt;
    end
    return cur;
  endfunction

  function automatic dsc_in_t make_item(logic [MODE_W-1:0] m, logic [IDX_W-1:0] idx,
                                        logic [LANES-1:0] bits);
    dsc_in_t it;
    it.mode      = m;
    it.arg_index = idx;
    it.row_bits  = bits;
    return it;
  endfunction

  function automatic void add_row(logic [MODE_W-1:0] m, logic [IDX_W-1:0] idx,
                                  logic [LANES-1:0] bits, bit has_ref,
                                  logic [LANES-1:0] mask, logic [COUNT_W-1:0] cnt);
    directed_row_t r;
    r.item                 = make_item(m, idx, bits);
    r.has_ref              = has_ref;
    r.ref_res.closure_mask = mask;
    r.ref_res.member_count = cnt;
    plan.push_back(r);
  endfunction

  // mostly within the active range so that rows and seeds matter
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(3) == 0) return IDX_W'($urandom_range(31));
    return IDX_W'($urandom_range(index_span - 1));
  endfunction

  function automatic logic [LANES-1:0] sparse_row();
    case ($urandom_range(4))
      0: return '0;
      1: return LANES'(1) << $urandom_range(31);
      2, 3: return $urandom & $urandom & $urandom;
      default: return $urandom & $urandom;
    endcase
  endfunction

  task automatic send_item(input dsc_in_t it, input bit has_ref, input dsc_out_t ref_res);
    dsc_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (it.mode)
      MODE_LOAD: graph_rows[it.arg_index] = it.row_bits;
      MODE_SEED: seed_set[it.arg_index] = 1'b1;
      MODE_CLEAR: seed_set = '0;
      MODE_COMPUTE: begin
        predicted.closure_mask = defended_closure();
        predicted.member_count = COUNT_W'($countones(predicted.closure_mask));
        pending_closures.push_back(has_ref ? ref_res : predicted);
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_closures.size() != 0) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [CFG_W-1:0] value);
    drain();
    // loads and seeds may still be landing
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    active_cnt = value;
    index_span = (value == 0 || int'(value) > ROWS) ? ROWS : int'(value);
  endtask

  // well-formed scenarios (rows, seeds, compute) with some noise items mixed in
  task automatic run_random(input int count);
    int sent;
    int kind;
    int start;
    int len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        send_item(make_item(MODE_W'($urandom_range(3)), IDX_W'($urandom_range(31)),
                            $urandom), 1'b0, '0);
        sent++;
      end else begin
        if ($urandom_range(3) == 0) begin
          send_item(make_item(MODE_CLEAR, pick_index(), $urandom), 1'b0, '0);
          sent++;
        end
        kind = $urandom_range(9);
        if (kind < 6) begin
          repeat ($urandom_range(1, 8)) begin
            send_item(make_item(MODE_LOAD, pick_index(), sparse_row()), 1'b0, '0);
            sent++;
          end
        end else if (kind < 9 || $urandom_range(1) == 0) begin
          // short attack chain, grows one link per round
          start = $urandom_range(31);
          len = $urandom_range(2, 10);
          for (int i = 0; i < len; i++) begin
            send_item(make_item(MODE_LOAD, IDX_W'((start + i) % ROWS),
                                LANES'(1) << ((start + i + 1) % ROWS)), 1'b0, '0);
            sent++;
          end
        end else begin
          // full chain over every row, the slowest closures
          for (int i = 0; i < ROWS; i++) begin
            send_item(make_item(MODE_LOAD, IDX_W'(i),
                                (i == ROWS - 1) ? '0 : LANES'(1) << (i + 1)), 1'b0, '0);
            sent++;
          end
        end
        repeat ($urandom_range(3)) begin
          send_item(make_item(MODE_SEED, pick_index(), $urandom), 1'b0, '0);
          sent++;
        end
        send_item(make_item(MODE_COMPUTE, IDX_W'($urandom_range(31)), $urandom), 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    dsc_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      quiet_cycles = 0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        if (pending_closures.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected closure item: mask %h count %0d",
                     out_data.closure_mask, out_data.member_count);
        end else begin
          want = pending_closures.pop_front();
          if (want.closure_mask !== out_data.closure_mask ||
              want.member_count !== out_data.member_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("closure mismatch: expected mask %h count %0d, got mask %h count %0d",
                       want.closure_mask, want.member_count,
                       out_data.closure_mask, out_data.member_count);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < ROWS; i++) graph_rows[i] = '0;
    seed_set   = '0;
    active_cnt = ACTIVE_RESET;

    add_row(MODE_COMPUTE, 0, '0, 1'b1, 32'hFFFF_FFFF, 32);
    add_row(MODE_LOAD, 0, 32'hFFFF_FFFF, 1'b0, '0, '0);
    add_row(MODE_COMPUTE, 31, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 0);
    add_row(MODE_SEED, 31, '0, 1'b0, '0, '0);
    add_row(MODE_COMPUTE, 0, '0, 1'b1, 32'h8000_0000, 1);
    add_row(MODE_SEED, 0, 32'hFFFF_FFFF, 1'b0, '0, '0);
    add_row(MODE_COMPUTE, 0, '0, 1'b1, 32'hFFFF_FFFF, 32);
    add_row(MODE_CLEAR, 31, 32'hFFFF_FFFF, 1'b0, '0, '0);
    add_row(MODE_COMPUTE, 0, '0, 1'b1, 32'h0000_0000, 0);
    add_row(MODE_LOAD, 0, '0, 1'b0, '0, '0);
    // self attacker never joins
    add_row(MODE_LOAD, 31, 32'h8000_0000, 1'b0, '0, '0);
    add_row(MODE_COMPUTE, 0, '0, 1'b1, 32'h7FFF_FFFF, 31);
    add_row(MODE_LOAD, 1, 32'h0000_0004, 1'b0, '0, '0);
    add_row(MODE_LOAD, 2, 32'h0000_0008, 1'b0, '0, '0);
    add_row(MODE_LOAD, 3, 32'h0000_0010, 1'b0, '0, '0);
    add_row(MODE_COMPUTE, 0, '0, 1'b0, '0, '0);
    add_row(MODE_LOAD, 30, 32'hFFFF_FFFF, 1'b0, '0, '0);
    add_row(MODE_COMPUTE, 0, '0, 1'b0, '0, '0);
    add_row(MODE_SEED, 30, '0, 1'b0, '0, '0);
    add_row(MODE_COMPUTE, 0, '0, 1'b0, '0, '0);
    add_row(MODE_LOAD, 30, '0, 1'b0, '0, '0);
    add_row(MODE_LOAD, 31, '0, 1'b0, '0, '0);
    add_row(MODE_SEED, 5, 32'hA5A5_5A5A, 1'b0, '0, '0);
    add_row(MODE_COMPUTE, 0, '0, 1'b0, '0, '0);

    send_idle_pct  = 22;
    recv_stall_pct = 82;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_item(plan[i].item, plan[i].has_ref, plan[i].ref_res);

    reconfigure(6'd0);
    run_random(60);
    reconfigure(6'd63);
    run_random(120);
    // hold the sender until every closure is back
    drain();
    run_random(125);

    send_idle_pct  = 82;
    recv_stall_pct = 22;
    reconfigure(6'd1);
    run_random(60);
    reconfigure(CFG_W'($urandom_range(2, 31)));
    run_random(245);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    reconfigure(6'd32);
    run_random(245);
    reconfigure(CFG_W'($urandom_range(1, 32)));
    run_random(245);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_closures.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
